>>> rtl/core/whp_pkg.sv
package whp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_file;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [12:0] bytes_per_sample;
    logic [15:0] block_align;
    logic [31:0] data_size;
    logic [31:0] data_start;
    logic [27:0] samples_per_buffer;
  } res_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TAG   = 3'd1;
  localparam logic [2:0] ST_NOT_PCM   = 3'd2;
  localparam logic [2:0] ST_ZERO_BITS = 3'd3;
  localparam logic [2:0] ST_MISSING   = 3'd4;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BASE_LEN = 32'd16;
  localparam logic [15:0] FMT_PCM      = 16'd1;

  // floor(x / 30) == (x * RATE_RECIP) >> RATE_SHIFT for every 32-bit x
  localparam logic [31:0] RATE_RECIP = 32'h8888_8889;
  localparam int          RATE_SHIFT = 36;

endpackage

>>> rtl/core/whp_core.sv
module whp_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  whp_pkg::req_t req,
  output logic          emit,
  output whp_pkg::res_t res
);
  import whp_pkg::*;

  typedef enum logic [8:0] {
    PH_RIFF_TAG   = 9'b000000001,
    PH_RIFF_SIZE  = 9'b000000010,
    PH_WAVE_TAG   = 9'b000000100,
    PH_CHUNK_ID   = 9'b000001000,
    PH_FMT_SIZE   = 9'b000010000,
    PH_FMT_BODY   = 9'b000100000,
    PH_SKIP       = 9'b001000000,
    PH_DATA_SIZE  = 9'b010000000,
    PH_OTHER_SIZE = 9'b100000000
  } phase_t;

  phase_t      phase, phase_next, cur_phase;
  logic [1:0]  fbi, fbi_next, cur_fbi;
  logic [31:0] aw, aw_next, cur_aw;
  logic [31:0] skip, skip_next, cur_skip;
  logic [31:0] offset, offset_next, cur_offset;
  logic [31:0] fmt_size, fmt_size_next, cur_fmt_size;
  logic        fmt_seen, fmt_seen_next, cur_fmt_seen;
  logic [15:0] held_ch, held_ch_next, cur_held_ch;
  logic [31:0] held_rate, held_rate_next, cur_held_rate;
  logic [15:0] held_align, held_align_next, cur_held_align;
  logic [15:0] held_bits, held_bits_next, cur_held_bits;
  logic        finished, finished_next, cur_finished;
  logic [63:0] rate_prod;

  logic        word_done;
  logic [31:0] body_len;
  logic [31:0] pos;
  logic [2:0]  status;
  logic [31:0] dsize;
  logic [31:0] dstart;

  always_comb begin
    if (req.first_byte) begin
      cur_phase      = PH_RIFF_TAG;
      cur_fbi        = '0;
      cur_aw         = '0;
      cur_skip       = '0;
      cur_offset     = '0;
      cur_fmt_size   = '0;
      cur_fmt_seen   = 1'b0;
      cur_held_ch    = '0;
      cur_held_rate  = '0;
      cur_held_align = '0;
      cur_held_bits  = '0;
      cur_finished   = 1'b0;
    end else begin
      cur_phase      = phase;
      cur_fbi        = fbi;
      cur_aw         = aw;
      cur_skip       = skip;
      cur_offset     = offset;
      cur_fmt_size   = fmt_size;
      cur_fmt_seen   = fmt_seen;
      cur_held_ch    = held_ch;
      cur_held_rate  = held_rate;
      cur_held_align = held_align;
      cur_held_bits  = held_bits;
      cur_finished   = finished;
    end

    phase_next      = cur_phase;
    fbi_next        = cur_fbi;
    aw_next         = cur_aw;
    skip_next       = cur_skip;
    offset_next     = cur_offset;
    fmt_size_next   = cur_fmt_size;
    fmt_seen_next   = cur_fmt_seen;
    held_ch_next    = cur_held_ch;
    held_rate_next  = cur_held_rate;
    held_align_next = cur_held_align;
    held_bits_next  = cur_held_bits;
    finished_next   = cur_finished;

    emit      = 1'b0;
    status    = ST_OK;
    dsize     = '0;
    dstart    = '0;
    word_done = 1'b0;
    body_len  = (cur_fmt_size < FMT_BASE_LEN) ? FMT_BASE_LEN : cur_fmt_size;
    pos       = body_len - cur_skip;

    if (!cur_finished) begin
      offset_next = cur_offset + 32'd1;

      if (cur_phase inside {PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_CHUNK_ID,
                            PH_FMT_SIZE, PH_DATA_SIZE, PH_OTHER_SIZE}) begin
        aw_next   = {req.data_byte, cur_aw[31:8]};
        fbi_next  = cur_fbi + 2'd1;
        word_done = (cur_fbi == 2'd3);
      end

      case (cur_phase)
        PH_RIFF_TAG: begin
          if (word_done) begin
            if (aw_next != TAG_RIFF) begin
              emit   = 1'b1;
              status = ST_BAD_TAG;
            end else begin
              phase_next = PH_RIFF_SIZE;
            end
          end
        end
        PH_RIFF_SIZE: begin
          if (word_done) begin
            phase_next = PH_WAVE_TAG;
          end
        end
        PH_WAVE_TAG: begin
          if (word_done) begin
            if (aw_next != TAG_WAVE) begin
              emit   = 1'b1;
              status = ST_BAD_TAG;
            end else begin
              phase_next = PH_CHUNK_ID;
            end
          end
        end
        PH_CHUNK_ID: begin
          if (word_done) begin
            if (aw_next == TAG_FMT) begin
              phase_next = PH_FMT_SIZE;
            end else if (aw_next == TAG_DATA) begin
              phase_next = PH_DATA_SIZE;
            end else begin
              phase_next = PH_OTHER_SIZE;
            end
          end
        end
        PH_FMT_SIZE: begin
          if (word_done) begin
            fmt_size_next = aw_next;
            skip_next     = (aw_next < FMT_BASE_LEN) ? FMT_BASE_LEN : aw_next;
            phase_next    = PH_FMT_BODY;
          end
        end
        PH_FMT_BODY: begin
          if (pos < 32'd2) begin
            if (pos[0]) begin
              aw_next[15:8] = req.data_byte;
              if ({req.data_byte, cur_aw[7:0]} != FMT_PCM) begin
                emit   = 1'b1;
                status = ST_NOT_PCM;
              end
            end else begin
              aw_next[7:0] = req.data_byte;
            end
          end else if (pos < 32'd4) begin
            held_ch_next[{pos[0], 3'b000} +: 8] = req.data_byte;
          end else if (pos < 32'd8) begin
            held_rate_next[{pos[1:0], 3'b000} +: 8] = req.data_byte;
          end else if (pos >= 32'd12 && pos < 32'd14) begin
            held_align_next[{pos[0], 3'b000} +: 8] = req.data_byte;
          end else if (pos >= 32'd14 && pos < FMT_BASE_LEN) begin
            held_bits_next[{pos[0], 3'b000} +: 8] = req.data_byte;
          end
          skip_next = cur_skip - 32'd1;
          if (skip_next == '0 && !emit) begin
            fmt_seen_next = 1'b1;
            aw_next       = '0;
            phase_next    = PH_CHUNK_ID;
          end
        end
        PH_SKIP: begin
          skip_next = cur_skip - 32'd1;
          if (skip_next == '0) begin
            phase_next = PH_CHUNK_ID;
          end
        end
        PH_DATA_SIZE: begin
          if (word_done) begin
            emit = 1'b1;
            if (!cur_fmt_seen) begin
              status = ST_MISSING;
            end else if (cur_held_bits == '0) begin
              status = ST_ZERO_BITS;
            end else begin
              status = ST_OK;
              dsize  = aw_next;
              dstart = cur_offset + 32'd1;
            end
          end
        end
        PH_OTHER_SIZE: begin
          if (word_done) begin
            skip_next  = aw_next;
            phase_next = (aw_next == '0) ? PH_CHUNK_ID : PH_SKIP;
          end
        end
        default: begin
          phase_next = PH_CHUNK_ID;
        end
      endcase

      if (!emit && req.end_of_file) begin
        emit   = 1'b1;
        status = (phase_next inside {PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG}) ?
                 ST_BAD_TAG : ST_MISSING;
      end

      if (emit) begin
        finished_next = 1'b1;
      end
    end

    res = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.channel_count      = cur_held_ch;
      res.sample_rate        = cur_held_rate;
      res.bytes_per_sample   = cur_held_bits[15:3];
      res.block_align        = cur_held_align;
      res.data_size          = dsize;
      res.data_start         = dstart;
      res.samples_per_buffer = rate_prod[RATE_SHIFT +: 28];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_RIFF_TAG;
      fbi        <= '0;
      aw         <= '0;
      skip       <= '0;
      offset     <= '0;
      fmt_size   <= '0;
      fmt_seen   <= 1'b0;
      held_ch    <= '0;
      held_rate  <= '0;
      held_align <= '0;
      held_bits  <= '0;
      finished   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      fbi        <= fbi_next;
      aw         <= aw_next;
      skip       <= skip_next;
      offset     <= offset_next;
      fmt_size   <= fmt_size_next;
      fmt_seen   <= fmt_seen_next;
      held_ch    <= held_ch_next;
      held_rate  <= held_rate_next;
      held_align <= held_align_next;
      held_bits  <= held_bits_next;
      finished   <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    rate_prod <= 64'(held_rate) * 64'(RATE_RECIP);
  end

endmodule

>>> rtl/core/wave_header_parser_top.sv
// channel   valid / ready          payload                 role
// request   req_valid / req_ready  req (whp_pkg::req_t)    one file byte per request
// result    res_valid / res_ready  res (whp_pkg::res_t)    at most one per file
//
// One request per cycle, unless a result stalls; any result shows in the next cycle.
// The rate is set by the byte-wide parse update between the state and result registers.
// Reset (rst, synchronous) clears the parse state and empties the result register.
// A stalled result holds; a request is still taken while the result is taken.
module wave_header_parser_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  whp_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output whp_pkg::res_t res
);
  import whp_pkg::*;

  logic req_fire;
  logic emit;
  res_t core_res;

  assign req_ready = !res_valid || res_ready;
  assign req_fire  = req_valid && req_ready;

  whp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (req_fire),
    .req    (req),
    .emit   (emit),
    .res    (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req_ready) begin
      res_valid <= req_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && emit) begin
      res <= core_res;
    end
  end

endmodule

>>> rtl/core/whp_checker.sv
module whp_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input whp_pkg::req_t req,
  input logic          res_valid,
  input logic          res_ready,
  input whp_pkg::res_t res
);
  import whp_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> req_ready)
    else $error("request stalled with empty result register");

  a_res_from_req: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_valid && req_ready))
    else $error("result without a request");

  a_res_drain: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !(req_valid && req_ready) |=> !res_valid)
    else $error("result repeated");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |->
      res.channel_count == '0 && res.sample_rate == '0 && res.data_size == '0 &&
      res.data_start == '0 && res.samples_per_buffer == '0)
    else $error("error result carries data");

endmodule

bind wave_header_parser_top whp_checker u_whp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

>>> dv/whp_checker.sv
`timescale 1ns / 1ps

module whp_scoreboard (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  whp_pkg::req_t req,
  input  logic          res_valid,
  input  logic          res_ready,
  input  whp_pkg::res_t res,
  output int            errors,
  output int            pending,
  output int            live_items
);
  import whp_pkg::*;

  localparam logic [31:0] RATE_DIV = 32'd30;

  typedef enum logic [3:0] {
    P_RIFF_ID,
    P_RIFF_LEN,
    P_WAVE_ID,
    P_CHUNK_ID,
    P_FMT_LEN,
    P_FMT_BODY,
    P_SKIP,
    P_DATA_LEN,
    P_OTHER_LEN
  } walk_e;

  walk_e       phase;
  logic [1:0]  idx;
  logic [31:0] word;
  logic [31:0] left;
  logic [31:0] offset;
  logic [31:0] fmt_len;
  bit          fmt_found;
  logic [15:0] hd_chans;
  logic [31:0] hd_rate;
  logic [15:0] hd_align;
  logic [15:0] hd_depth;
  bit          done;

  res_t headers_due[$];

  task automatic clear_parse();
    phase     = P_RIFF_ID;
    idx       = '0;
    word      = '0;
    left      = '0;
    offset    = '0;
    fmt_len   = '0;
    fmt_found = 1'b0;
    hd_chans  = '0;
    hd_rate   = '0;
    hd_align  = '0;
    hd_depth  = '0;
    done      = 1'b0;
  endtask

  task automatic parse_byte(input req_t r, output bit made_one, output res_t made);
    logic [31:0] here;
    logic [31:0] span;
    logic [31:0] pos;
    logic [31:0] dsz;
    logic [31:0] dst;
    logic [2:0]  st;
    bit          full;
    bit          stop;
    made_one = 1'b0;
    made     = '0;
    full     = 1'b0;
    stop     = 1'b0;
    st       = ST_OK;
    dsz      = '0;
    dst      = '0;
    if (r.first_byte) clear_parse();
    if (done) return;
    here   = offset;
    offset = offset + 32'd1;
    if (phase != P_FMT_BODY && phase != P_SKIP) begin
      word = {r.data_byte, word[31:8]};
      idx  = idx + 2'd1;
      full = (idx == 2'd0);
    end
    case (phase)
      P_RIFF_ID: begin
        if (full) begin
          if (word != TAG_RIFF) begin
            stop = 1'b1;
            st   = ST_BAD_TAG;
          end else begin
            phase = P_RIFF_LEN;
          end
        end
      end
      P_RIFF_LEN: begin
        if (full) phase = P_WAVE_ID;
      end
      P_WAVE_ID: begin
        if (full) begin
          if (word != TAG_WAVE) begin
            stop = 1'b1;
            st   = ST_BAD_TAG;
          end else begin
            phase = P_CHUNK_ID;
          end
        end
      end
      P_CHUNK_ID: begin
        if (full) begin
          if (word == TAG_FMT) phase = P_FMT_LEN;
          else if (word == TAG_DATA) phase = P_DATA_LEN;
          else phase = P_OTHER_LEN;
        end
      end
      P_FMT_LEN: begin
        if (full) begin
          fmt_len = word;
          left    = (word < FMT_BASE_LEN) ? FMT_BASE_LEN : word;
          phase   = P_FMT_BODY;
        end
      end
      P_FMT_BODY: begin
        span = (fmt_len < FMT_BASE_LEN) ? FMT_BASE_LEN : fmt_len;
        pos  = span - left;
        if (pos < 2) begin
          word[8*pos[0] +: 8] = r.data_byte;
          if (pos == 1 && word[15:0] != FMT_PCM) begin
            stop = 1'b1;
            st   = ST_NOT_PCM;
          end
        end else if (pos < 4) begin
          hd_chans[8*(pos-2) +: 8] = r.data_byte;
        end else if (pos < 8) begin
          hd_rate[8*(pos-4) +: 8] = r.data_byte;
        end else if (pos >= 12 && pos < 14) begin
          hd_align[8*(pos-12) +: 8] = r.data_byte;
        end else if (pos >= 14 && pos < FMT_BASE_LEN) begin
          hd_depth[8*(pos-14) +: 8] = r.data_byte;
        end
        left = left - 32'd1;
        if (left == 0) begin
          fmt_found = 1'b1;
          word      = '0;
          phase     = P_CHUNK_ID;
        end
      end
      P_SKIP: begin
        left = left - 32'd1;
        if (left == 0) phase = P_CHUNK_ID;
      end
      P_DATA_LEN: begin
        if (full) begin
          stop = 1'b1;
          if (!fmt_found) begin
            st = ST_MISSING;
          end else if (hd_depth == 0) begin
            st = ST_ZERO_BITS;
          end else begin
            dsz = word;
            dst = here + 32'd1;
          end
        end
      end
      P_OTHER_LEN: begin
        if (full) begin
          left  = word;
          phase = (word == 0) ? P_CHUNK_ID : P_SKIP;
        end
      end
      default: phase = P_CHUNK_ID;
    endcase
    if (!stop && r.end_of_file) begin
      stop = 1'b1;
      st   = (phase == P_RIFF_ID || phase == P_RIFF_LEN || phase == P_WAVE_ID) ?
             ST_BAD_TAG : ST_MISSING;
    end
    if (stop) begin
      done        = 1'b1;
      made_one    = 1'b1;
      made.status = st;
      if (st == ST_OK) begin
        made.channel_count      = hd_chans;
        made.sample_rate        = hd_rate;
        made.bytes_per_sample   = hd_depth[15:3];
        made.block_align        = hd_align;
        made.data_size          = dsz;
        made.data_start         = dst;
        made.samples_per_buffer = 28'(hd_rate / RATE_DIV);
      end
    end
  endtask

  function automatic int differs(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    res_t made;
    bit   made_one;
    int   bad;
    bad = 0;
    if (rst) begin
      clear_parse();
      headers_due.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (headers_due.size() == 0) begin
          $error("status: expected no result, got %0h", res.status);
          bad++;
        end else begin
          want = headers_due.pop_front();
          bad += differs("status", want.status, res.status);
          bad += differs("channel_count", want.channel_count, res.channel_count);
          bad += differs("sample_rate", want.sample_rate, res.sample_rate);
          bad += differs("bytes_per_sample", want.bytes_per_sample, res.bytes_per_sample);
          bad += differs("block_align", want.block_align, res.block_align);
          bad += differs("data_size", want.data_size, res.data_size);
          bad += differs("data_start", want.data_start, res.data_start);
          bad += differs("samples_per_buffer", want.samples_per_buffer,
                         res.samples_per_buffer);
        end
      end
      if (req_valid && req_ready) begin
        if (req.first_byte || !done) live_items <= live_items + 1;
        parse_byte(req, made_one, made);
        if (made_one) begin
          headers_due.push_back(made);
        end
      end
    end
    errors  <= errors + bad;
    pending <= headers_due.size();
  end

endmodule

>>> dv/tb_wave_header_parser_top.sv
`timescale 1ns / 1ps

module tb_wave_header_parser_top;
  import whp_pkg::*;

  localparam int ITEMS        = 1750;
  localparam int RESET_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    int          junk;
    bit          with_fmt;
    bit          fmt_twice;
    logic [31:0] fmt_size;
    logic [15:0] fmt_tag;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [31:0] byte_rate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] data_size;
    int          bad_tag;
    int          keep;
    int          tail;
    bit          mark_first;
    bit          mark_end;
    bit          wild;
    bit          noise;
  } wave_plan_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  int errors;
  int pending;
  int live_items;

  bit squeeze  = 1'b0;
  bit calm     = 1'b0;
  bit tx_quiet = 1'b0;

  logic [7:0] stream[$];

  wave_header_parser_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  whp_scoreboard u_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .errors     (errors),
    .pending    (pending),
    .live_items (live_items)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic wave_plan_t clean_plan();
    wave_plan_t p;
    p.junk       = 0;
    p.with_fmt   = 1'b1;
    p.fmt_twice  = 1'b0;
    p.fmt_size   = FMT_BASE_LEN;
    p.fmt_tag    = FMT_PCM;
    p.channels   = 16'd2;
    p.rate       = 32'd48000;
    p.byte_rate  = 32'd192000;
    p.align      = 16'd4;
    p.bits       = 16'd16;
    p.data_size  = 32'd1024;
    p.bad_tag    = -1;
    p.keep       = -1;
    p.tail       = 0;
    p.mark_first = 1'b1;
    p.mark_end   = 1'b1;
    p.wild       = 1'b0;
    p.noise      = 1'b0;
    return p;
  endfunction

  task automatic put32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) stream.push_back(w[8*i +: 8]);
  endtask

  task automatic put16(input logic [15:0] w);
    stream.push_back(w[7:0]);
    stream.push_back(w[15:8]);
  endtask

  task automatic add_fmt(input wave_plan_t p);
    put32(TAG_FMT);
    put32(p.fmt_size);
    put16(p.fmt_tag);
    put16(p.channels);
    put32(p.rate);
    put32(p.byte_rate);
    put16(p.align);
    put16(p.bits);
    if (p.fmt_size > FMT_BASE_LEN) begin
      repeat ((p.fmt_size - FMT_BASE_LEN > 8) ? 8 : p.fmt_size - FMT_BASE_LEN)
        stream.push_back(8'($urandom));
    end
  endtask

  task automatic put_request(input req_t r);
    if (!calm) begin
      if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
      if (!tx_quiet && $urandom_range(0, 3) == 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic send_file(input wave_plan_t p);
    wave_plan_t  first_fmt;
    logic [31:0] junk_id;
    logic [31:0] junk_len;
    req_t        r;
    int          last;
    stream.delete();
    if (p.noise) begin
      repeat ($urandom_range(1, 20)) stream.push_back(8'($urandom));
    end else begin
      put32(TAG_RIFF);
      put32($urandom);
      put32(TAG_WAVE);
      repeat (p.junk) begin
        junk_id = $urandom;
        if (junk_id == TAG_FMT || junk_id == TAG_DATA) junk_id ^= 32'h1;
        junk_len = p.wild ? $urandom : $urandom_range(0, 6);
        put32(junk_id);
        put32(junk_len);
        repeat ((junk_len > 8) ? 8 : junk_len) stream.push_back(8'($urandom));
      end
      if (p.with_fmt) begin
        if (p.fmt_twice) begin
          first_fmt          = p;
          first_fmt.fmt_size = FMT_BASE_LEN;
          first_fmt.fmt_tag  = FMT_PCM;
          first_fmt.channels = 16'($urandom);
          first_fmt.rate     = $urandom;
          first_fmt.align    = 16'($urandom);
          first_fmt.bits     = 16'($urandom);
          add_fmt(first_fmt);
        end
        add_fmt(p);
      end
      put32(TAG_DATA);
      put32(p.data_size);
      repeat (p.tail) stream.push_back(8'($urandom));
      if (p.bad_tag >= 0)
        stream[(p.bad_tag < 4) ? p.bad_tag : p.bad_tag + 4] ^= 8'($urandom_range(1, 255));
      if (p.keep == 0) p.keep = $urandom_range(1, stream.size());
      if (p.keep > 0) begin
        while (stream.size() > p.keep) void'(stream.pop_back());
      end
    end
    last = stream.size() - 1;
    for (int i = 0; i <= last; i++) begin
      r.data_byte   = stream[i];
      r.first_byte  = (i == 0) && p.mark_first;
      r.end_of_file = ((i == last) && p.mark_end) || (p.noise && $urandom_range(0, 15) == 0);
      put_request(r);
    end
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : sink
    bit held;
    bit quiet;
    held  = 1'b0;
    quiet = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (squeeze && !held) begin
        held = 1'b1;
        res_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm) begin
        if ($urandom_range(0, 49) == 0) quiet = !quiet;
        if (!quiet && $urandom_range(0, 3) == 0) begin
          res_ready <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk);
        end
      end
      res_ready <= 1'b1;
    end
  end

  initial begin : stimulus
    wave_plan_t p;
    int         roll;
    bit         paused;
    paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < 16; k++) begin
      p = clean_plan();
      case (k)
        0: p.mark_first = 1'b0;
        1: p.keep = 1;
        2: p.bad_tag = 0;
        3: p.bad_tag = 7;
        4: p.fmt_tag = 16'h0003;
        5: p.with_fmt = 1'b0;
        6: p.bits = '0;
        7: p.bits = 16'd7;
        8: begin
          p.fmt_size = 32'd2;
          p.junk     = 1;
        end
        9: begin
          p.fmt_size  = 32'd18;
          p.fmt_twice = 1'b1;
        end
        10: begin
          p.channels  = '1;
          p.rate      = '1;
          p.byte_rate = '1;
          p.align     = '1;
          p.bits      = '1;
          p.data_size = '1;
        end
        11: begin
          p.channels  = '0;
          p.rate      = '0;
          p.byte_rate = '0;
          p.align     = '0;
          p.bits      = 16'd8;
          p.data_size = '0;
          p.fmt_size  = 32'd20;
        end
        12: begin
          p.keep     = 30;
          p.mark_end = 1'b0;
        end
        13: p.keep = 26;
        14: p.keep = 9;
        default: begin
          p.wild = 1'b1;
          p.junk = 1;
          p.keep = 40;
        end
      endcase
      send_file(p);
    end

    while (live_items < ITEMS) begin
      if (live_items > 300) squeeze <= 1'b1;
      if (live_items > 900 && !paused) begin
        paused = 1'b1;
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (live_items > ITEMS - 200) calm <= 1'b1;
      p    = clean_plan();
      roll = $urandom_range(0, 19);
      p.junk      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      p.with_fmt  = ($urandom_range(0, 11) != 0);
      p.fmt_twice = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 5))
        0: p.fmt_size = $urandom_range(0, 15);
        1: p.fmt_size = 32'd18;
        2: p.fmt_size = $urandom_range(17, 24);
        default: p.fmt_size = FMT_BASE_LEN;
      endcase
      if ($urandom_range(0, 9) == 0) p.fmt_tag = 16'($urandom);
      p.channels   = 16'($urandom);
      p.rate       = $urandom;
      p.byte_rate  = $urandom;
      p.align      = 16'($urandom);
      p.bits       = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
      p.data_size  = $urandom;
      if ($urandom_range(0, 11) == 0) p.bad_tag = $urandom_range(0, 7);
      p.tail       = $urandom_range(0, 3);
      p.mark_first = ($urandom_range(0, 15) != 0);
      p.mark_end   = ($urandom_range(0, 3) != 0);
      if (roll < 3) begin
        p.keep = 0;
        p.wild = $urandom_range(0, 1);
        if (p.wild) p.fmt_size = $urandom;
      end else if (roll < 6) begin
        p.noise = 1'b1;
      end
      send_file(p);
    end

    req_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/whp_pkg.sv
rtl/core/whp_core.sv
rtl/core/wave_header_parser_top.sv
rtl/core/whp_checker.sv
dv/whp_checker.sv
dv/tb_wave_header_parser_top.sv
